[design/assert_macros.svh]
// Assertion macros shared by the damage tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SDT_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SDT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[design/sdt_pkg.sv]
// Types, register indexes and rectangle helpers for the damage tracker.
package sdt_pkg;

  // Register indexes on the write port
  localparam logic [2:0] CFG_SURFACE_X      = 3'd0;
  localparam logic [2:0] CFG_SURFACE_Y      = 3'd1;
  localparam logic [2:0] CFG_SURFACE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SURFACE_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_SCREEN_WIDTH   = 3'd4;
  localparam logic [2:0] CFG_SCREEN_HEIGHT  = 3'd5;
  localparam logic [2:0] CFG_FORCE_FULL     = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Frames buffered between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } box_t;

  typedef struct packed {
    logic ok;
    box_t box;
  } clip_t;

  typedef struct packed {
    logic signed [15:0] surface_x;
    logic signed [15:0] surface_y;
    logic [14:0]        surface_width;
    logic [14:0]        surface_height;
    logic [14:0]        screen_width;
    logic [14:0]        screen_height;
    logic               force_full;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic               has_rect;
    logic               frame_end;
    logic               pending_buffer;
    logic               shown_buffer;
    logic               culled;
  } rect_item_t;

  typedef struct packed {
    logic               damage_valid;
    logic signed [15:0] damage_x;
    logic signed [15:0] damage_y;
    logic [14:0]        damage_w;
    logic [14:0]        damage_h;
    logic               paint_valid;
    logic signed [15:0] paint_x;
    logic signed [15:0] paint_y;
    logic [14:0]        paint_w;
    logic [14:0]        paint_h;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
  } damage_item_t;

  // One frame handed from front to back
  typedef struct packed {
    logic clear;
    box_t region;
  } frame_t;

  function automatic logic box_empty(box_t b);
    return (b.w <= 16'sd0) || (b.h <= 16'sd0);
  endfunction

  // Bounding box of two rectangles; edges at 17 bits, result cut to 16
  function automatic box_t box_union(box_t a, box_t b);
    logic signed [16:0] ax1, ay1, bx1, by1, x1, y1;
    logic signed [15:0] x0, y0;
    logic signed [17:0] w, h;
    box_t o;
    ax1 = {a.x[15], a.x} + {a.w[15], a.w};
    ay1 = {a.y[15], a.y} + {a.h[15], a.h};
    bx1 = {b.x[15], b.x} + {b.w[15], b.w};
    by1 = {b.y[15], b.y} + {b.h[15], b.h};
    x0  = (a.x < b.x) ? a.x : b.x;
    y0  = (a.y < b.y) ? a.y : b.y;
    x1  = (ax1 > bx1) ? ax1 : bx1;
    y1  = (ay1 > by1) ? ay1 : by1;
    w   = {x1[16], x1} - {{2{x0[15]}}, x0};
    h   = {y1[16], y1} - {{2{y0[15]}}, y0};
    o.x = x0;
    o.y = y0;
    o.w = w[15:0];
    o.h = h[15:0];
    if (box_empty(b)) begin
      o = a;
    end else if (box_empty(a)) begin
      o = b;
    end
    return o;
  endfunction

  // Intersection of two rectangles; zero box when nothing overlaps
  function automatic clip_t box_clip(box_t a, box_t b);
    logic signed [16:0] ax1, ay1, bx1, by1, x1, y1;
    logic signed [15:0] x0, y0;
    logic signed [17:0] w, h;
    clip_t o;
    ax1 = {a.x[15], a.x} + {a.w[15], a.w};
    ay1 = {a.y[15], a.y} + {a.h[15], a.h};
    bx1 = {b.x[15], b.x} + {b.w[15], b.w};
    by1 = {b.y[15], b.y} + {b.h[15], b.h};
    x0  = (a.x > b.x) ? a.x : b.x;
    y0  = (a.y > b.y) ? a.y : b.y;
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    w   = {x1[16], x1} - {{2{x0[15]}}, x0};
    h   = {y1[16], y1} - {{2{y0[15]}}, y0};
    if ((x1 <= x0) || (y1 <= y0)) begin
      o = '0;
    end else begin
      o.ok     = 1'b1;
      o.box.x  = x0;
      o.box.y  = y0;
      o.box.w  = w[15:0];
      o.box.h  = h[15:0];
    end
    return o;
  endfunction

  // Rectangle at the origin with the given unsigned size
  function automatic box_t origin_box(logic [14:0] w, logic [14:0] h);
    box_t o;
    o.x = '0;
    o.y = '0;
    o.w = {1'b0, w};
    o.h = {1'b0, h};
    return o;
  endfunction

endpackage

[design/sdt_if.sv]
// Valid/ready channels for damage rectangles and damage results.
interface sdt_rect_if;
  logic                   valid;
  logic                   ready;
  sdt_pkg::rect_item_t    data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sdt_damage_if;
  logic                   valid;
  logic                   ready;
  sdt_pkg::damage_item_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/sdt_front.sv]
// Front end: accepts rectangles, keeps the running box, posts frames.
module sdt_front (
  input  logic                clk,
  input  logic                rst,
  input  sdt_pkg::cfg_t       cfg,
  sdt_rect_if.sink            rects,
  input  logic                queue_full,
  output logic                push,
  output sdt_pkg::frame_t     push_frame
);

  sdt_pkg::box_t running_box;
  logic          list_nonempty;

  sdt_pkg::box_t running_box_next;
  logic          list_nonempty_next;
  sdt_pkg::box_t rect;
  logic          accept;
  logic          use_full;

  assign rects.ready = !queue_full;
  assign accept      = rects.valid && rects.ready;

  // Merge this beat's rectangle into the running box
  always_comb begin
    rect.x = rects.data.rect_x;
    rect.y = rects.data.rect_y;
    rect.w = rects.data.rect_w;
    rect.h = rects.data.rect_h;
    if (rects.data.has_rect) begin
      running_box_next = sdt_pkg::box_union(running_box, rect);
    end else begin
      running_box_next = running_box;
    end
    list_nonempty_next = list_nonempty || rects.data.has_rect;
  end

  // Classify the frame on its last beat
  always_comb begin
    use_full = cfg.force_full || !list_nonempty_next || !rects.data.pending_buffer;
    push_frame.clear = rects.data.culled ||
                       (!rects.data.pending_buffer && !rects.data.shown_buffer);
    if (use_full) begin
      push_frame.region = sdt_pkg::origin_box(cfg.surface_width, cfg.surface_height);
    end else begin
      push_frame.region = running_box_next;
    end
    push = accept && rects.data.frame_end;
  end

  // Hold the running box between beats, drop it at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      running_box   <= '0;
      list_nonempty <= 1'b0;
    end else if (accept) begin
      if (rects.data.frame_end) begin
        running_box   <= '0;
        list_nonempty <= 1'b0;
      end else begin
        running_box   <= running_box_next;
        list_nonempty <= list_nonempty_next;
      end
    end
  end

endmodule

[design/sdt_queue.sv]
// Small frame queue between the front end and the back end.
module sdt_queue #(
  parameter int DEPTH = sdt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sdt_pkg::frame_t push_frame,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output sdt_pkg::frame_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdt_pkg::frame_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            head_valid;
  logic            head_free;
  logic            stored;
  logic            to_mem;
  logic            from_mem;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = head_valid;

  // The head register takes the oldest stored frame, or a pushed frame
  // directly when nothing is stored behind it
  assign head_free = pop || !head_valid;
  assign stored    = (count != CW'(head_valid));
  assign from_mem  = head_free && stored;
  assign to_mem    = push && !(head_free && !stored);

  // Store pushed frames and load the head
  always_ff @(posedge clk) begin
    if (to_mem) begin
      entries[wr_ptr] <= push_frame;
    end
    if (from_mem) begin
      head <= entries[rd_ptr];
    end else if (head_free && push) begin
      head <= push_frame;
    end
  end

  // Advance pointers, the head flag and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (to_mem) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (from_mem) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (head_free) begin
        head_valid <= stored || push;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/sdt_back.sv]
// Back end: merges stored damage, clips to surface and screen, emits results.
module sdt_back (
  input  logic            clk,
  input  logic            rst,
  input  sdt_pkg::cfg_t   cfg,
  input  logic            nonempty,
  input  sdt_pkg::frame_t head,
  output logic            pop,
  sdt_damage_if.source    damage
);

  logic adv;

  // Stored damage of the previous frame
  sdt_pkg::box_t last_box;
  logic          last_valid;

  // Stage 1: union with stored damage
  logic          s1_valid;
  logic          s1_clear;
  sdt_pkg::box_t s1_box;
  // Stage 2: clipped to the surface
  logic          s2_valid;
  logic          s2_dval;
  sdt_pkg::box_t s2_box;
  // Stage 3: translated to screen space
  logic          s3_valid;
  logic          s3_dval;
  sdt_pkg::box_t s3_box;
  logic signed [15:0] s3_scr_x;
  logic signed [15:0] s3_scr_y;
  // Stage 4: clipped to the screen
  logic          s4_valid;
  logic          s4_dval;
  logic          s4_pval;
  sdt_pkg::box_t s4_box;
  sdt_pkg::box_t s4_paint;

  logic                  out_valid;
  sdt_pkg::damage_item_t out_data;

  sdt_pkg::box_t   union_box;
  sdt_pkg::clip_t  surf_clip;
  sdt_pkg::clip_t  scr_clip;
  sdt_pkg::box_t   scr_box;
  logic signed [16:0] scr_x_sum;
  logic signed [16:0] scr_y_sum;
  logic signed [16:0] src_x_diff;
  logic signed [16:0] src_y_diff;
  sdt_pkg::damage_item_t out_next;

  assign adv          = !out_valid || damage.ready;
  assign pop          = adv && nonempty && !s1_valid;
  assign damage.valid = out_valid;
  assign damage.data  = out_data;

  // Merge the popped region with the stored damage
  always_comb begin
    if (last_valid) begin
      union_box = sdt_pkg::box_union(head.region, last_box);
    end else begin
      union_box = head.region;
    end
  end

  // Clip the merged region to the surface
  assign surf_clip = sdt_pkg::box_clip(s1_box,
                       sdt_pkg::origin_box(cfg.surface_width, cfg.surface_height));

  // Translate damage into screen space
  assign scr_x_sum = {s2_box.x[15], s2_box.x} + {cfg.surface_x[15], cfg.surface_x};
  assign scr_y_sum = {s2_box.y[15], s2_box.y} + {cfg.surface_y[15], cfg.surface_y};

  // Clip the screen-space region to the screen
  always_comb begin
    scr_box.x = s3_scr_x;
    scr_box.y = s3_scr_y;
    scr_box.w = s3_box.w;
    scr_box.h = s3_box.h;
    scr_clip  = sdt_pkg::box_clip(scr_box,
                  sdt_pkg::origin_box(cfg.screen_width, cfg.screen_height));
  end

  // Form the result beat
  always_comb begin
    src_x_diff = {s4_paint.x[15], s4_paint.x} - {cfg.surface_x[15], cfg.surface_x};
    src_y_diff = {s4_paint.y[15], s4_paint.y} - {cfg.surface_y[15], cfg.surface_y};
    out_next   = '0;
    if (s4_dval) begin
      out_next.damage_valid = 1'b1;
      out_next.damage_x     = s4_box.x;
      out_next.damage_y     = s4_box.y;
      out_next.damage_w     = s4_box.w[14:0];
      out_next.damage_h     = s4_box.h[14:0];
      if (s4_pval) begin
        out_next.paint_valid = 1'b1;
        out_next.paint_x     = s4_paint.x;
        out_next.paint_y     = s4_paint.y;
        out_next.paint_w     = s4_paint.w[14:0];
        out_next.paint_h     = s4_paint.h[14:0];
        out_next.source_x    = src_x_diff[15:0];
        out_next.source_y    = src_y_diff[15:0];
      end
    end
  end

  // Advance payload through the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_clear <= head.clear;
      s1_box   <= union_box;
      s2_dval  <= !s1_clear && surf_clip.ok;
      s2_box   <= surf_clip.box;
      s3_dval  <= s2_dval;
      s3_box   <= s2_box;
      s3_scr_x <= scr_x_sum[15:0];
      s3_scr_y <= scr_y_sum[15:0];
      s4_dval  <= s3_dval;
      s4_pval  <= s3_dval && scr_clip.ok;
      s4_box   <= s3_box;
      s4_paint <= scr_clip.box;
      out_data <= out_next;
    end
  end

  // Advance stage valids and update the stored damage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      out_valid  <= 1'b0;
      last_valid <= 1'b0;
      last_box   <= '0;
    end else if (adv) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
      if (s1_valid) begin
        last_valid <= !s1_clear && surf_clip.ok;
        last_box   <= surf_clip.box;
      end
    end
  end

endmodule

[design/surface_damage_tracker.sv]
// Top level of the per-frame surface damage tracker.
// The tracker takes one damage rectangle beat per cycle while the queue is
// not full and keeps the frame's bounding box in the front end; the beat
// marked frame_end posts the frame into a queue of QUEUE_DEPTH frames, and
// the back end turns it into one result beat through its stages. It pops
// no frame while the last is in stage 1, as merging with the previous
// frame's stored damage (union, then surface clip) spans two stages; beats
// in between keep the front end busy, and the queue lets either side stall
// on its own. Configuration registers must be written through wr_en /
// wr_index / wr_data only while no frame is in flight; the block does not enforce it.
`include "assert_macros.svh"

module surface_damage_tracker #(
  parameter int QUEUE_DEPTH = sdt_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [sdt_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [sdt_pkg::CFG_DATA_W-1:0]  wr_data,
  sdt_rect_if.sink                        rects,
  sdt_damage_if.source                    damage
);

  sdt_pkg::cfg_t   cfg;
  logic            queue_full;
  logic            push;
  sdt_pkg::frame_t push_frame;
  logic            pop;
  logic            nonempty;
  sdt_pkg::frame_t head;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        sdt_pkg::CFG_SURFACE_X:      cfg.surface_x      <= wr_data;
        sdt_pkg::CFG_SURFACE_Y:      cfg.surface_y      <= wr_data;
        sdt_pkg::CFG_SURFACE_WIDTH:  cfg.surface_width  <= wr_data[14:0];
        sdt_pkg::CFG_SURFACE_HEIGHT: cfg.surface_height <= wr_data[14:0];
        sdt_pkg::CFG_SCREEN_WIDTH:   cfg.screen_width   <= wr_data[14:0];
        sdt_pkg::CFG_SCREEN_HEIGHT:  cfg.screen_height  <= wr_data[14:0];
        sdt_pkg::CFG_FORCE_FULL:     cfg.force_full     <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  sdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rects      (rects),
    .queue_full (queue_full),
    .push       (push),
    .push_frame (push_frame)
  );

  sdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (queue_full),
    .pop        (pop),
    .nonempty   (nonempty),
    .head       (head)
  );

  sdt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .damage   (damage)
  );

  // A result without damage carries nothing else
  `SDT_ASSERT_IMPLY(a_no_damage_zero, clk, rst,
    damage.valid && !damage.data.damage_valid,
    damage.data.damage_x == '0 && damage.data.damage_w == '0 && !damage.data.paint_valid,
    "result without damage carries nonzero fields")

  // Paint only where damage exists, and never an empty paint area
  `SDT_ASSERT_IMPLY(a_paint_has_damage, clk, rst,
    damage.valid && damage.data.paint_valid,
    damage.data.damage_valid && damage.data.paint_w != '0 && damage.data.paint_h != '0,
    "paint region without damage or with empty size")

  // Reported damage is never empty
  `SDT_ASSERT_IMPLY(a_damage_nonempty, clk, rst,
    damage.valid && damage.data.damage_valid,
    damage.data.damage_w != '0 && damage.data.damage_h != '0,
    "damage region reported with empty size")

endmodule

[tb/sv/damage_check.sv]
`timescale 1ns / 1ps
// Damage tracker checker: tracks config writes, predicts each frame's result and compares beats.
module damage_check
  import sdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  sdt_rect_if                    rects,
  sdt_damage_if                  damage,
  output int                     fail_count,
  output int                     backlog
);

  // Edges of a box, widened so that no sum wraps
  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } span_t;

  cfg_t         setup;
  box_t         run_box;
  logic         frame_has_rect;
  box_t         prev_damage;
  logic         prev_damage_ok;
  damage_item_t frame_results_q[$];

  // A box covers nothing when either size is zero or negative
  function automatic logic is_void(box_t b);
    return b.w[15] || (b.w == '0) || b.h[15] || (b.h == '0);
  endfunction

  function automatic span_t edges(box_t b);
    span_t s;
    s.x0 = b.x;
    s.y0 = b.y;
    s.x1 = s.x0 + b.w;
    s.y1 = s.y0 + b.h;
    return s;
  endfunction

  // Build a box from its edges, cutting every field back to 16 bits
  function automatic box_t corners(int x0, int y0, int x1, int y1);
    box_t b;
    b.x = 16'(x0);
    b.y = 16'(y0);
    b.w = 16'(x1 - x0);
    b.h = 16'(y1 - y0);
    return b;
  endfunction

  function automatic box_t merge_box(box_t a, box_t b);
    span_t sa, sb;
    if (is_void(b)) return a;
    if (is_void(a)) return b;
    sa = edges(a);
    sb = edges(b);
    return corners((sa.x0 < sb.x0) ? sa.x0 : sb.x0, (sa.y0 < sb.y0) ? sa.y0 : sb.y0,
                   (sa.x1 > sb.x1) ? sa.x1 : sb.x1, (sa.y1 > sb.y1) ? sa.y1 : sb.y1);
  endfunction

  function automatic box_t overlap_box(box_t a, box_t b, output logic hit);
    span_t sa, sb;
    int    x0, y0, x1, y1;
    box_t  o;
    sa  = edges(a);
    sb  = edges(b);
    x0  = (sa.x0 > sb.x0) ? sa.x0 : sb.x0;
    y0  = (sa.y0 > sb.y0) ? sa.y0 : sb.y0;
    x1  = (sa.x1 < sb.x1) ? sa.x1 : sb.x1;
    y1  = (sa.y1 < sb.y1) ? sa.y1 : sb.y1;
    hit = (x1 > x0) && (y1 > y0);
    o   = '0;
    if (hit) o = corners(x0, y0, x1, y1);
    return o;
  endfunction

  // Fold one rectangle beat in; on frame end, queue the frame's damage result
  task automatic track_rect(rect_item_t it);
    box_t         r, region, surf, dmg, on_screen, scrn, vis;
    logic         hit;
    damage_item_t res;
    if (it.has_rect) begin
      r.x = it.rect_x;
      r.y = it.rect_y;
      r.w = it.rect_w;
      r.h = it.rect_h;
      frame_has_rect = 1'b1;
      run_box = merge_box(run_box, r);
    end
    if (!it.frame_end) return;
    res = '0;
    if (it.culled || (!it.pending_buffer && !it.shown_buffer)) begin
      prev_damage_ok = 1'b0;
    end else begin
      surf = corners(0, 0, setup.surface_width, setup.surface_height);
      if (setup.force_full || !frame_has_rect || !it.pending_buffer) region = surf;
      else region = run_box;
      if (prev_damage_ok) region = merge_box(region, prev_damage);
      dmg = overlap_box(region, surf, hit);
      if (hit) begin
        prev_damage      = dmg;
        prev_damage_ok   = 1'b1;
        res.damage_valid = 1'b1;
        res.damage_x     = dmg.x;
        res.damage_y     = dmg.y;
        res.damage_w     = dmg.w[14:0];
        res.damage_h     = dmg.h[14:0];
        // Move to screen space, keep the size, then clip to the screen
        on_screen   = dmg;
        on_screen.x = dmg.x + setup.surface_x;
        on_screen.y = dmg.y + setup.surface_y;
        scrn = corners(0, 0, setup.screen_width, setup.screen_height);
        vis  = overlap_box(on_screen, scrn, hit);
        if (hit) begin
          res.paint_valid = 1'b1;
          res.paint_x     = vis.x;
          res.paint_y     = vis.y;
          res.paint_w     = vis.w[14:0];
          res.paint_h     = vis.h[14:0];
          res.source_x    = vis.x - setup.surface_x;
          res.source_y    = vis.y - setup.surface_y;
        end
      end else begin
        prev_damage_ok = 1'b0;
      end
    end
    run_box        = '0;
    frame_has_rect = 1'b0;
    frame_results_q.push_back(res);
  endtask

  task automatic cmp_field(string name, logic signed [16:0] want, logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare one result beat against the oldest predicted frame
  task automatic compare_beat(damage_item_t got);
    damage_item_t want;
    if (frame_results_q.size() == 0) begin
      $error("damage beat arrived with no frame waiting for it");
      fail_count++;
      return;
    end
    want = frame_results_q.pop_front();
    cmp_field("damage_valid", want.damage_valid, got.damage_valid);
    cmp_field("damage_x", want.damage_x, got.damage_x);
    cmp_field("damage_y", want.damage_y, got.damage_y);
    cmp_field("damage_w", want.damage_w, got.damage_w);
    cmp_field("damage_h", want.damage_h, got.damage_h);
    cmp_field("paint_valid", want.paint_valid, got.paint_valid);
    cmp_field("paint_x", want.paint_x, got.paint_x);
    cmp_field("paint_y", want.paint_y, got.paint_y);
    cmp_field("paint_w", want.paint_w, got.paint_w);
    cmp_field("paint_h", want.paint_h, got.paint_h);
    cmp_field("source_x", want.source_x, got.source_x);
    cmp_field("source_y", want.source_y, got.source_y);
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      setup          = '0;
      run_box        = '0;
      frame_has_rect = 1'b0;
      prev_damage    = '0;
      prev_damage_ok = 1'b0;
      fail_count     = 0;
      frame_results_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_SURFACE_X:      setup.surface_x      = wr_data;
          CFG_SURFACE_Y:      setup.surface_y      = wr_data;
          CFG_SURFACE_WIDTH:  setup.surface_width  = wr_data[14:0];
          CFG_SURFACE_HEIGHT: setup.surface_height = wr_data[14:0];
          CFG_SCREEN_WIDTH:   setup.screen_width   = wr_data[14:0];
          CFG_SCREEN_HEIGHT:  setup.screen_height  = wr_data[14:0];
          CFG_FORCE_FULL:     setup.force_full     = wr_data[0];
          default: ;
        endcase
      end
      if (damage.valid && damage.ready) compare_beat(damage.data);
      if (rects.valid && rects.ready) track_rect(rects.data);
    end
    backlog <= frame_results_q.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Damage tracker testbench top: clock, reset, stimulus, receiver stalls and verdict.
module tb;
  import sdt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PCT      = 17;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  int                     fails;
  int                     backlog;
  int                     cycle_count = 0;
  logic                   quiet;
  logic                   hold_go;
  logic                   hold_done;
  int                     hold_left;
  cfg_t                   setup;

  sdt_rect_if   rect_ch();
  sdt_damage_if dmg_ch();

  surface_damage_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .rects    (rect_ch),
    .damage   (dmg_ch)
  );

  damage_check mon (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .rects      (rect_ch),
    .damage     (dmg_ch),
    .fail_count (fails),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive result ready: random stalls, one long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      dmg_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left > 0) begin
      dmg_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      dmg_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      dmg_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic cfg_t mk_setup(int sx, int sy, int sw, int sh, int cw, int ch, bit ff);
    cfg_t c;
    c.surface_x      = 16'(sx);
    c.surface_y      = 16'(sy);
    c.surface_width  = 15'(sw);
    c.surface_height = 15'(sh);
    c.screen_width   = 15'(cw);
    c.screen_height  = 15'(ch);
    c.force_full     = ff;
    return c;
  endfunction

  function automatic cfg_t rand_setup();
    cfg_t c;
    c = mk_setup(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                 $urandom_range(1, 900), $urandom_range(1, 700),
                 $urandom_range(1, 1280), $urandom_range(1, 800), $urandom_range(9) == 0);
    if ($urandom_range(7) == 0) c.surface_x = 16'($urandom);
    if ($urandom_range(7) == 0) c.surface_y = 16'($urandom);
    if ($urandom_range(7) == 0) c.surface_width = 15'($urandom);
    if ($urandom_range(7) == 0) c.surface_height = 15'($urandom);
    return c;
  endfunction

  function automatic rect_item_t rect_beat(int x, int y, int w, int h, bit has, bit last,
                                           bit pend, bit shown, bit cull);
    rect_item_t it;
    it.rect_x         = 16'(x);
    it.rect_y         = 16'(y);
    it.rect_w         = 16'(w);
    it.rect_h         = 16'(h);
    it.has_rect       = has;
    it.frame_end      = last;
    it.pending_buffer = pend;
    it.shown_buffer   = shown;
    it.culled         = cull;
    return it;
  endfunction

  // Rectangles mostly near the surface, some wild, some empty
  function automatic rect_item_t rand_item(bit last);
    rect_item_t it;
    int         span_x, span_y;
    span_x    = int'(setup.surface_width) + 64;
    span_y    = int'(setup.surface_height) + 64;
    it.rect_x = 16'(int'($urandom_range(span_x + 64)) - 64);
    it.rect_y = 16'(int'($urandom_range(span_y + 64)) - 64);
    it.rect_w = 16'($urandom_range(1, span_x));
    it.rect_h = 16'($urandom_range(1, span_y));
    case ($urandom_range(9))
      0: begin
        it.rect_x = 16'($urandom);
        it.rect_y = 16'($urandom);
        it.rect_w = 16'($urandom);
        it.rect_h = 16'($urandom);
      end
      1: it.rect_w = 16'(-int'($urandom_range(40)));
      2: it.rect_h = 16'(-int'($urandom_range(40)));
      default: ;
    endcase
    it.has_rect  = ($urandom_range(99) < 90);
    it.frame_end = last;
    if (last) begin
      it.pending_buffer = ($urandom_range(99) < 75);
      it.shown_buffer   = $urandom_range(1);
      it.culled         = ($urandom_range(99) < 8);
    end else begin
      it.pending_buffer = $urandom_range(1);
      it.shown_buffer   = $urandom_range(1);
      it.culled         = $urandom_range(1);
    end
    return it;
  endfunction

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // Write every register; unused upper bits carry noise
  task automatic load_setup(cfg_t c);
    setup = c;
    put_reg(CFG_SURFACE_X, c.surface_x);
    put_reg(CFG_SURFACE_Y, c.surface_y);
    put_reg(CFG_SURFACE_WIDTH, {1'($urandom), c.surface_width});
    put_reg(CFG_SURFACE_HEIGHT, {1'($urandom), c.surface_height});
    put_reg(CFG_SCREEN_WIDTH, {1'($urandom), c.screen_width});
    put_reg(CFG_SCREEN_HEIGHT, {1'($urandom), c.screen_height});
    put_reg(CFG_FORCE_FULL, {15'($urandom), c.force_full});
    wr_en <= 1'b0;
  endtask

  // Offer one beat, with random gaps ahead of it, and hold until taken
  task automatic push_rect(rect_item_t it);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      rect_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rect_ch.valid <= 1'b1;
    rect_ch.data  <= it;
    @(posedge clk);
    while (rect_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Pause the sender until every frame result is back, then let the pipe drain
  task automatic settle();
    rect_ch.valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(inout int sent);
    int n;
    n = $urandom_range(4);
    repeat (n) push_rect(rand_item(1'b0));
    push_rect(rand_item(1'b1));
    sent += n + 1;
  endtask

  initial begin
    cfg_t plan;
    int   quota;
    int   sent;
    rst           <= 1'b1;
    wr_en         <= 1'b0;
    wr_index      <= '0;
    wr_data       <= '0;
    rect_ch.valid <= 1'b0;
    rect_ch.data  <= '0;
    quiet         <= 1'b0;
    hold_go       <= 1'b0;
    setup          = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, culled, no buffer, merged boxes, empty rect only
    load_setup(mk_setup(10, -5, 640, 480, 800, 600, 0));
    push_rect(rect_beat(0, 0, 0, 0, 0, 1, 1, 0, 0));
    push_rect(rect_beat(0, 0, 0, 0, 0, 1, 0, 0, 1));
    push_rect(rect_beat(5, 5, 10, 10, 1, 0, 0, 0, 0));
    push_rect(rect_beat(100, 50, 20, 30, 1, 1, 1, 1, 0));
    push_rect(rect_beat(0, 0, 0, 5, 1, 1, 1, 1, 0));
    push_rect(rect_beat(0, 0, 0, 0, 0, 1, 0, 0, 0));
    // Extreme coordinates: negative sizes skipped, wrapped box lands off the surface
    push_rect(rect_beat(-32768, 32767, 32767, -1, 1, 0, 1, 1, 1));
    push_rect(rect_beat(32767, -32768, 32767, 32767, 1, 0, 0, 1, 0));
    push_rect(rect_beat(-32768, -32768, -32768, -32768, 1, 1, 1, 0, 0));
    push_rect(rect_beat(-20, -20, 100, 100, 1, 1, 1, 1, 0));
    push_rect(rect_beat(600, 470, 100, 100, 1, 1, 1, 1, 0));
    push_rect(rect_beat(1, 1, 1, 1, 1, 1, 0, 1, 0));
    push_rect(rect_beat(0, 0, 1, 1, 1, 1, 1, 1, 1));
    push_rect(rect_beat(1000, 1000, 5, 5, 1, 1, 1, 1, 0));
    settle();

    // Directed: forced full damage on a layer parked off screen
    load_setup(mk_setup(-32768, 32767, 32767, 32767, 32767, 32767, 1));
    push_rect(rect_beat(0, 0, 0, 0, 0, 1, 1, 1, 0));
    push_rect(rect_beat(7, 7, 3, 3, 1, 1, 1, 0, 0));
    settle();

    // Directed: zero-size screen, so nothing paints
    load_setup(mk_setup(32767, -32768, 100, 100, 0, 0, 0));
    push_rect(rect_beat(10, 10, 20, 20, 1, 1, 1, 1, 0));
    settle();

    // Directed: partly on screen, source offsets nonzero
    load_setup(mk_setup(-50, -60, 32767, 32767, 32767, 32767, 0));
    push_rect(rect_beat(0, 0, 0, 0, 0, 1, 1, 1, 1));
    push_rect(rect_beat(30, 40, 100, 100, 1, 1, 1, 1, 0));
    push_rect(rect_beat(32000, 32000, 767, 767, 1, 1, 1, 1, 0));

    // Random frames over a spread of settings
    for (int p = 0; p < 8; p++) begin
      plan  = rand_setup();
      quota = 250;
      case (p)
        0: quota = 350;
        1: plan.force_full = 1'b1;
        2: begin
          plan.screen_width  = '0;
          plan.screen_height = 15'($urandom_range(1, 800));
        end
        3: plan = mk_setup(32767, 32767, 32767, 32767, 32767, 32767, 0);
        4: begin
          plan.surface_x = 16'sh8000;
          plan.surface_y = 16'sh8000;
        end
        5: begin
          plan.surface_width = '0;
          quota = 100;
        end
        6: quota = 200;
        7: quota = 300;
        default: ;
      endcase
      settle();
      load_setup(plan);
      quiet <= (p == 0);
      // Stall the receiver while frames keep coming, so the queue backs up
      if (p == 6) begin
        hold_go <= 1'b1;
        repeat (80) push_rect(rand_item(1'b1));
      end
      sent = 0;
      while (sent < quota) send_frame(sent);
    end
    settle();

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
